[rtl/lptc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lptc_pkg;

    localparam int unsigned CAPACITY_DEF = 256;
    localparam int unsigned TAG_W        = 64;
    localparam int unsigned DIGEST_W     = 256;
    localparam int unsigned STATUS_W     = 3;
    localparam int unsigned SLOT_OUT_W   = 8;
    localparam int unsigned COUNT_W      = 32;
    localparam int unsigned RES_OUT_W    = 9;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_CONFLICT = 3'd2,
        ST_INSERTED = 3'd3,
        ST_RESIDENT = 3'd4
    } t_status;

    // Cell moves: keep, take the neighbor's entry as part of a ring rotation,
    // or take it only when the cell sits at or ahead of the shift position.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_SHIFT
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                valid;
        logic [TAG_W-1:0]    tag;
        logic [DIGEST_W-1:0] digest;
    } t_entry;

endpackage
`default_nettype wire

[rtl/lptc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface lptc_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] page_offset;
    logic [63:0] digest_w0;
    logic [63:0] digest_w1;
    logic [63:0] digest_w2;
    logic [63:0] digest_w3;

    modport source (output valid, cmd, page_offset, digest_w0, digest_w1, digest_w2,
                    digest_w3, input ready);
    modport sink   (input valid, cmd, page_offset, digest_w0, digest_w1, digest_w2,
                    digest_w3, output ready);
endinterface

interface lptc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  slot;
    logic        evicted_valid;
    logic [63:0] evicted_offset;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] evict_total;
    logic [8:0]  resident_count;
    logic [8:0]  resident_high_water;

    modport source (output valid, status, slot, evicted_valid, evicted_offset, hit_total,
                    miss_total, evict_total, resident_count, resident_high_water,
                    input ready);
    modport sink   (input valid, status, slot, evicted_valid, evicted_offset, hit_total,
                    miss_total, evict_total, resident_count, resident_high_water,
                    output ready);
endinterface
`default_nettype wire

[rtl/lptc_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module lptc_cell #(
    parameter int unsigned IDX    = 0,
    parameter int unsigned SLOT_W = 8,
    parameter int unsigned POS_W  = 8
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  lptc_pkg::t_cell_op     i_op,
    input  wire [POS_W-1:0]        i_pos,
    input  lptc_pkg::t_entry       i_ent,
    input  wire [SLOT_W-1:0]       i_slot,
    output lptc_pkg::t_entry       o_ent,
    output logic [SLOT_W-1:0]      o_slot
);

    localparam logic [POS_W-1:0] MyPos = POS_W'(IDX);

    logic                          r_valid;
    logic [lptc_pkg::TAG_W-1:0]    r_tag;
    logic [lptc_pkg::DIGEST_W-1:0] r_digest;
    logic [SLOT_W-1:0]             r_slot;
    logic                          w_take;

    always_comb begin
        case (i_op)
            lptc_pkg::CELL_ROTATE: w_take = 1'b1;
            lptc_pkg::CELL_SHIFT:  w_take = (MyPos <= i_pos);
            default:               w_take = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= i_ent.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_tag    <= i_ent.tag;
            r_digest <= i_ent.digest;
            r_slot   <= i_slot;
        end
    end

    assign o_ent  = {r_valid, r_tag, r_digest};
    assign o_slot = r_slot;

endmodule
`default_nettype wire

[rtl/lru_page_tag_cache_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Fully associative LRU cache of page tags, each with a 256-bit digest.
// Input channel i_in: cmd 0 looks a page offset up, cmd 1 fills it after an
// external load. Output channel o_out: one result per input transfer with
// status, slot, eviction and the running statistics.
// Entries live in a chain of CAPACITY cells kept in recency order, the most
// recent at the head. A command rotates the chain once around, comparing the
// head cell against the tag in each step of the scan; an update step then
// shifts the chain to move or insert the entry at the head, and an output
// step loads the output register. A new input transfer is accepted only
// once the previous result has been loaded into the output register.
// Reset (synchronous, active low) empties all entries and clears the counters.
// The output register holds a result until the receiver takes it; a new
// command is accepted meanwhile, and its result waits in the last stage
// until the output register frees up.
module lru_page_tag_cache_top #(
    parameter int unsigned CAPACITY = lptc_pkg::CAPACITY_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lptc_in_if.sink    i_in,
    lptc_out_if.source o_out
);

    localparam int unsigned SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned POS_W  = SLOT_W;
    localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CapCnt  = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] LastCnt = CNT_W'(CAPACITY - 1);
    localparam logic [POS_W-1:0] LastPos = POS_W'(CAPACITY - 1);

    lptc_pkg::t_entry  w_ent  [CAPACITY];
    logic [SLOT_W-1:0] w_slot [CAPACITY];
    lptc_pkg::t_entry  w_head_ent;
    logic [SLOT_W-1:0] w_head_slot;
    lptc_pkg::t_cell_op w_op;
    logic [POS_W-1:0]  w_pos;

    lptc_pkg::t_state  r_state, n_state;
    logic              r_cmd;
    logic [lptc_pkg::TAG_W-1:0]    r_tag;
    logic [lptc_pkg::DIGEST_W-1:0] r_digest;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_found;
    logic              r_dig_ok;
    logic [POS_W-1:0]  r_pos;
    logic [SLOT_W-1:0] r_hslot;
    logic [lptc_pkg::COUNT_W-1:0] r_hits, r_misses, r_evicts;
    logic [CNT_W-1:0]  r_resident;

    lptc_pkg::t_status r_res_status;
    logic [SLOT_W-1:0] r_res_slot;
    logic              r_res_ev;
    logic [lptc_pkg::TAG_W-1:0] r_res_ev_tag;

    logic              r_out_valid;
    lptc_pkg::t_status r_out_status;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_ev;
    logic [lptc_pkg::TAG_W-1:0] r_out_ev_tag;
    logic [lptc_pkg::COUNT_W-1:0] r_out_hits, r_out_misses, r_out_evicts;
    logic [CNT_W-1:0]  r_out_res;

    logic w_in_xfer, w_out_load, w_head_match, w_head_dig, w_full, w_insert, w_touch;

    assign w_in_xfer  = i_in.valid && i_in.ready;
    assign w_out_load = (r_state == lptc_pkg::S_OUT) && (!r_out_valid || o_out.ready);
    assign w_head_match = w_ent[0].valid && (w_ent[0].tag == r_tag);
    assign w_head_dig   = (w_ent[0].digest == r_digest);
    assign w_full   = (r_resident == CapCnt);
    assign w_insert = !r_found && r_cmd;
    assign w_touch  = r_found && r_dig_ok;

    // Chain of cells; the head takes the tail during the scan rotation.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        if (k == 0) begin : g_head
            lptc_cell #(.IDX(k), .SLOT_W(SLOT_W), .POS_W(POS_W)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(w_op), .i_pos(w_pos),
                .i_ent(w_head_ent), .i_slot(w_head_slot),
                .o_ent(w_ent[k]), .o_slot(w_slot[k])
            );
        end else begin : g_body
            lptc_cell #(.IDX(k), .SLOT_W(SLOT_W), .POS_W(POS_W)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_op(w_op), .i_pos(w_pos),
                .i_ent(w_ent[k-1]), .i_slot(w_slot[k-1]),
                .o_ent(w_ent[k]), .o_slot(w_slot[k])
            );
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lptc_pkg::S_IDLE:   if (w_in_xfer) n_state = lptc_pkg::S_SCAN;
            lptc_pkg::S_SCAN:   if (r_cnt == LastCnt) n_state = lptc_pkg::S_UPDATE;
            lptc_pkg::S_UPDATE: n_state = lptc_pkg::S_OUT;
            lptc_pkg::S_OUT:    if (w_out_load) n_state = lptc_pkg::S_IDLE;
            default:            n_state = lptc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_op        = lptc_pkg::CELL_HOLD;
        w_pos       = r_pos;
        w_head_ent  = w_ent[CAPACITY-1];
        w_head_slot = w_slot[CAPACITY-1];
        case (r_state)
            lptc_pkg::S_SCAN: begin
                w_op = lptc_pkg::CELL_ROTATE;
            end
            lptc_pkg::S_UPDATE: begin
                w_head_ent.valid  = 1'b1;
                w_head_ent.tag    = r_tag;
                w_head_ent.digest = r_digest;
                if (w_touch) begin
                    w_op        = lptc_pkg::CELL_SHIFT;
                    w_head_slot = r_hslot;
                end else if (w_insert) begin
                    w_op  = lptc_pkg::CELL_SHIFT;
                    w_pos = LastPos;
                    // Valid slots are always 0..n-1, so a free slot is the count.
                    w_head_slot = w_full ? w_slot[CAPACITY-1] : SLOT_W'(r_resident);
                end
            end
            default: begin
                w_op = lptc_pkg::CELL_HOLD;
            end
        endcase
    end

    assign i_in.ready = (r_state == lptc_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lptc_pkg::S_IDLE;
            r_found     <= 1'b0;
            r_cnt       <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_resident  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_xfer) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else if (r_state == lptc_pkg::S_SCAN) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_head_match && !r_found) r_found <= 1'b1;
            end
            if (r_state == lptc_pkg::S_UPDATE) begin
                if (w_touch && !r_cmd && r_hits != '1) r_hits <= r_hits + 1'b1;
                if (!r_found && !r_cmd && r_misses != '1) r_misses <= r_misses + 1'b1;
                if (w_insert && w_full && r_evicts != '1) r_evicts <= r_evicts + 1'b1;
                if (w_insert && !w_full) r_resident <= r_resident + 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_cmd    <= i_in.cmd;
            r_tag    <= i_in.page_offset;
            r_digest <= {i_in.digest_w3, i_in.digest_w2, i_in.digest_w1, i_in.digest_w0};
        end
        // After c rotations the head holds the entry from chain position CAPACITY - c.
        if (r_state == lptc_pkg::S_SCAN && w_head_match && !r_found) begin
            r_pos    <= (r_cnt == '0) ? '0 : POS_W'(CapCnt - r_cnt);
            r_dig_ok <= w_head_dig;
            r_hslot  <= w_slot[0];
        end
        if (r_state == lptc_pkg::S_UPDATE) begin
            r_res_ev     <= w_insert && w_full;
            r_res_ev_tag <= (w_insert && w_full) ? w_ent[CAPACITY-1].tag : '0;
            if (r_found && !r_dig_ok) begin
                r_res_status <= lptc_pkg::ST_CONFLICT;
                r_res_slot   <= '0;
            end else if (w_touch) begin
                r_res_status <= r_cmd ? lptc_pkg::ST_RESIDENT : lptc_pkg::ST_HIT;
                r_res_slot   <= r_hslot;
            end else if (!r_cmd) begin
                r_res_status <= lptc_pkg::ST_MISS;
                r_res_slot   <= '0;
            end else begin
                r_res_status <= lptc_pkg::ST_INSERTED;
                r_res_slot   <= w_head_slot;
            end
        end
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_slot   <= r_res_slot;
            r_out_ev     <= r_res_ev;
            r_out_ev_tag <= r_res_ev_tag;
            r_out_hits   <= r_hits;
            r_out_misses <= r_misses;
            r_out_evicts <= r_evicts;
            r_out_res    <= r_resident;
        end
    end

    // The resident count never falls, so it is its own high-water mark.
    assign o_out.valid               = r_out_valid;
    assign o_out.status              = r_out_status;
    assign o_out.slot                = lptc_pkg::SLOT_OUT_W'(r_out_slot);
    assign o_out.evicted_valid       = r_out_ev;
    assign o_out.evicted_offset      = r_out_ev_tag;
    assign o_out.hit_total           = r_out_hits;
    assign o_out.miss_total          = r_out_misses;
    assign o_out.evict_total         = r_out_evicts;
    assign o_out.resident_count      = lptc_pkg::RES_OUT_W'(r_out_res);
    assign o_out.resident_high_water = lptc_pkg::RES_OUT_W'(r_out_res);

    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_resident <= CapCnt)
        else $error("resident count above capacity");

    a_upd_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lptc_pkg::S_UPDATE |=> r_state == lptc_pkg::S_OUT)
        else $error("update not followed by output stage");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lptc_pkg::S_IDLE && r_resident != '0) |-> w_ent[0].valid)
        else $error("head cell empty while entries are resident");

    a_scan_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lptc_pkg::S_SCAN && r_cnt == '0) |-> !r_found)
        else $error("scan started with a stale match");

endmodule
`default_nettype wire

[test/lptc_scoreboard.sv]
`timescale 1ns / 1ps
class lptc_scoreboard;
    typedef struct {
        lptc_pkg::t_status status;
        logic [7:0]        slot;
        logic              ev_valid;
        logic [63:0]       ev_offset;
        logic [31:0]       hits;
        logic [31:0]       misses;
        logic [31:0]       evicts;
        logic [8:0]        resident;
        logic [8:0]        high_water;
    } t_page_result;

    bit          line_valid [256];
    logic [63:0] line_tag [256];
    logic [255:0] line_digest [256];
    int unsigned line_age [256];
    logic [31:0] hits, misses, evicts;
    int unsigned resident, high_water;
    t_page_result pending_results[$];
    int errors;

    function new();
        for (int i = 0; i < 256; i++) begin
            line_valid[i] = 0;
            line_age[i] = 0;
        end
        hits = 0;
        misses = 0;
        evicts = 0;
        resident = 0;
        high_water = 0;
        errors = 0;
    endfunction

    function logic [31:0] bump(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    // Works out the cache update for one accepted command.
    function void note_command(logic cmd, logic [63:0] offset, logic [255:0] digest);
        t_page_result r;
        int found, target, worst;
        int unsigned age;
        found = -1;
        r.slot = 0;
        r.ev_valid = 0;
        r.ev_offset = 0;
        for (int i = 0; i < 256; i++)
            if (found < 0 && line_valid[i] && line_tag[i] == offset) found = i;
        if (found >= 0) begin
            if (line_digest[found] != digest) begin
                r.status = lptc_pkg::ST_CONFLICT;
            end else begin
                age = line_age[found];
                for (int i = 0; i < 256; i++)
                    if (line_valid[i] && i != found && line_age[i] < age) line_age[i]++;
                line_age[found] = 0;
                r.slot = found[7:0];
                if (cmd == 1'b0) begin
                    hits = bump(hits);
                    r.status = lptc_pkg::ST_HIT;
                end else begin
                    r.status = lptc_pkg::ST_RESIDENT;
                end
            end
        end else if (cmd == 1'b0) begin
            misses = bump(misses);
            r.status = lptc_pkg::ST_MISS;
        end else begin
            target = -1;
            for (int i = 0; i < 256; i++)
                if (target < 0 && !line_valid[i]) target = i;
            if (target < 0) begin
                worst = 0;
                for (int i = 0; i < 256; i++)
                    if (line_age[i] > line_age[worst]) worst = i;
                target = worst;
                r.ev_valid = 1;
                r.ev_offset = line_tag[worst];
                line_valid[worst] = 0;
                evicts = bump(evicts);
            end else begin
                resident++;
            end
            for (int i = 0; i < 256; i++)
                if (line_valid[i]) line_age[i]++;
            line_valid[target] = 1;
            line_tag[target] = offset;
            line_digest[target] = digest;
            line_age[target] = 0;
            if (resident > high_water) high_water = resident;
            r.slot = target[7:0];
            r.status = lptc_pkg::ST_INSERTED;
        end
        r.hits = hits;
        r.misses = misses;
        r.evicts = evicts;
        r.resident = resident[8:0];
        r.high_water = high_water[8:0];
        pending_results.push_back(r);
    endfunction

    function void report(string what);
        $display("mismatch: %s", what);
        errors++;
    endfunction

    function void check_result(t_page_result got);
        t_page_result e;
        if (pending_results.size() == 0) begin
            report("result with none expected");
            return;
        end
        e = pending_results.pop_front();
        if (got.status != e.status)
            report($sformatf("status %0d, expected %0d", got.status, e.status));
        if (got.slot != e.slot) report($sformatf("slot %0d, expected %0d", got.slot, e.slot));
        if (got.ev_valid != e.ev_valid) report("evicted_valid");
        if (got.ev_offset != e.ev_offset)
            report($sformatf("evicted_offset %h, expected %h", got.ev_offset, e.ev_offset));
        if (got.hits != e.hits) report($sformatf("hit_total %0d vs %0d", got.hits, e.hits));
        if (got.misses != e.misses) report($sformatf("miss_total %0d vs %0d", got.misses, e.misses));
        if (got.evicts != e.evicts) report($sformatf("evict_total %0d vs %0d", got.evicts, e.evicts));
        if (got.resident != e.resident)
            report($sformatf("resident_count %0d vs %0d", got.resident, e.resident));
        if (got.high_water != e.high_water)
            report($sformatf("high_water %0d vs %0d", got.high_water, e.high_water));
    endfunction
endclass

[test/lru_page_tag_cache_top_tb.sv]
`timescale 1ns / 1ps
module lru_page_tag_cache_top_tb;

    localparam int STALL_LIMIT = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    lptc_in_if  cmd_ch ();
    lptc_out_if res_ch ();

    lptc_scoreboard cache_sb = new();
    bit quiet_phase = 0;
    bit stim_done = 0;
    int idle_count = 0;

    // Pool of recent tags and digests so lookups and refills hit often.
    logic [63:0]  known_tag [$];
    logic [255:0] known_digest [$];

    lru_page_tag_cache_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_ch.sink),
        .o_out  (res_ch.source)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        cmd_ch.valid <= 0;
        cmd_ch.cmd <= 0;
        cmd_ch.page_offset <= 0;
        cmd_ch.digest_w0 <= 0;
        cmd_ch.digest_w1 <= 0;
        cmd_ch.digest_w2 <= 0;
        cmd_ch.digest_w3 <= 0;
        res_ch.ready <= 0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Valid stays high from one transfer to the next unless an idle burst comes.
    task automatic send_command(logic cmd, logic [63:0] offset, logic [255:0] digest);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        cmd_ch.valid <= 1;
        cmd_ch.cmd <= cmd;
        cmd_ch.page_offset <= offset;
        {cmd_ch.digest_w3, cmd_ch.digest_w2, cmd_ch.digest_w1, cmd_ch.digest_w0} <= digest;
        do @(posedge i_clk); while (!cmd_ch.ready);
        cache_sb.note_command(cmd, offset, digest);
    endtask

    task automatic send_known(logic cmd, int idx, bit spoil);
        logic [255:0] d;
        d = known_digest[idx];
        if (spoil) d[$urandom_range(0, 255)] ^= 1'b1;
        send_command(cmd, known_tag[idx], d);
    endtask

    task automatic fill_new(logic [63:0] offset, logic [255:0] digest);
        send_command(1, offset, digest);
        known_tag.push_back(offset);
        known_digest.push_back(digest);
        if (known_tag.size() > 300) begin
            void'(known_tag.pop_front());
            void'(known_digest.pop_front());
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready)
                cache_sb.check_result('{lptc_pkg::t_status'(res_ch.status), res_ch.slot,
                    res_ch.evicted_valid, res_ch.evicted_offset, res_ch.hit_total,
                    res_ch.miss_total, res_ch.evict_total, res_ch.resident_count,
                    res_ch.resident_high_water});
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
        end
    end

    // Receiver stalls in bursts.
    initial begin
        @(posedge i_rst_n);
        forever begin
            res_ch.ready <= 1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            if (!quiet_phase) begin
                res_ch.ready <= 0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_count >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int idx;
        int pick;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extremes, both commands, conflicts, refill of a resident page.
        send_command(0, 64'h0, 256'h0);
        fill_new(64'h0, 256'h0);
        send_command(0, 64'h0, 256'h0);
        fill_new(64'hFFFF_FFFF_FFFF_FFFF, {256{1'b1}});
        send_command(0, 64'hFFFF_FFFF_FFFF_FFFF, {256{1'b1}});
        send_known(0, 1, 1);
        send_known(1, 1, 1);
        send_known(1, 0, 0);
        send_command(0, 64'h5555_AAAA_5555_AAAA, {4{64'hAAAA_5555_AAAA_5555}});
        fill_new(64'h8000_0000_0000_0000, {4{64'h5555_AAAA_5555_AAAA}});
        send_known(0, 2, 0);

        // Mostly new fills mixed with accesses to known pages, so the LRU order is exercised.
        for (int n = 0; n < 270; n++) begin
            if ($urandom_range(0, 3) == 0 && known_tag.size() > 0)
                send_known($urandom_range(0, 1), $urandom_range(0, known_tag.size() - 1), 0);
            else
                fill_new(rand64(), {rand64(), rand64(), rand64(), rand64()});
        end

        for (int n = 0; n < 120; n++) begin
            if (n == 90) quiet_phase = 1;
            pick = $urandom_range(0, 9);
            idx = $urandom_range(0, known_tag.size() - 1);
            if (pick < 4) send_known(0, idx, 0);
            else if (pick < 5) send_known($urandom_range(0, 1), idx, 1);
            else if (pick < 6) send_known(1, idx, 0);
            else if (pick < 9) fill_new(rand64(), {rand64(), rand64(), rand64(), rand64()});
            else send_command(0, rand64(), {rand64(), rand64(), rand64(), rand64()});
        end
        cmd_ch.valid <= 0;

        while (cache_sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (cache_sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
